>>> sv/lphj_pkg.sv
// Package with shared types, constants and register indexes for the hash join table.
package lphj_pkg;

	localparam int LOG2_MAX_BUCKETS = 10;
	localparam int STORE_DEPTH = 1 << LOG2_MAX_BUCKETS;
	localparam int IDX_W = LOG2_MAX_BUCKETS;
	localparam int SLOT_W = 64;
	localparam int CNT_W = 48;
	localparam int SUM_W = 64;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [3:0] BUCKET_BITS_RST = 4'd10;
	localparam logic [31:0] EMPTY_KEY_RST = 32'hFFFF_FFFF;
	localparam logic [31:0] HASH_MULT_RST = 32'd2654435761;
	localparam logic [31:0] VAL_MULT_RST = 32'd42;
	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [2:0] {
		CFG_BUCKET_BITS = 3'd0,
		CFG_EMPTY_KEY = 3'd1,
		CFG_HASH_MULT = 3'd2,
		CFG_VAL_MULT = 3'd3,
		CFG_KEEP_FULL = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_INSERT = 2'd1,
		OP_PROBE = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0] op;
		logic [31:0] key;
	} in_item_t;

	typedef struct packed {
		logic found;
		logic [31:0] match_value;
		logic status;
		logic [47:0] match_count;
		logic [63:0] value_sum;
	} out_item_t;

	// Classified work handed from front to back.
	typedef struct packed {
		op_t op;
		logic [31:0] skey;
		logic [31:0] empty;
		logic [31:0] value;
		logic [IDX_W-1:0] hash;
		logic [IDX_W-1:0] mask;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_READ,
		ST_WAIT,
		ST_CHECK,
		ST_DONE
	} back_state_t;

	function automatic logic [3:0] used_bits(input logic [3:0] b);
		logic [3:0] r;
		r = b;
		if (b == 4'd0) r = 4'd1;
		if (b > 4'(LOG2_MAX_BUCKETS)) r = 4'(LOG2_MAX_BUCKETS);
		return r;
	endfunction

endpackage

>>> sv/lphj_ram.sv
// Generic single-port RAM with registered read data.
module lphj_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] addr,
	input logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

>>> sv/lphj_front.sv
// Front end: holds configuration, hashes and classifies items into jobs.
module lphj_front import lphj_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_idx,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input in_item_t in_item,
	output logic job_valid,
	input logic job_ready,
	output job_t job
);

	logic [3:0] bucket_bits_q;
	logic [31:0] empty_key_q, hash_mult_q, val_mult_q;
	logic keep_full_q;
	logic busy_s1;
	in_item_t item_s1;
	logic [31:0] hprod_s1, vprod_s1;
	logic [3:0] bits;
	logic [IDX_W-1:0] mask;
	logic [31:0] mask32;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_bits_q <= BUCKET_BITS_RST;
			empty_key_q <= EMPTY_KEY_RST;
			hash_mult_q <= HASH_MULT_RST;
			val_mult_q <= VAL_MULT_RST;
			keep_full_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_BUCKET_BITS: bucket_bits_q <= cfg_data[3:0];
				CFG_EMPTY_KEY: empty_key_q <= cfg_data;
				CFG_HASH_MULT: hash_mult_q <= cfg_data;
				CFG_VAL_MULT: val_mult_q <= cfg_data;
				CFG_KEEP_FULL: keep_full_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign in_ready = !busy_s1 || job_ready;
	assign job_valid = busy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (in_ready) begin
			busy_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
			hprod_s1 <= in_item.key * hash_mult_q;
			vprod_s1 <= in_item.key * val_mult_q;
		end
	end

	always_comb begin
		bits = used_bits(bucket_bits_q);
		mask32 = (32'd1 << bits) - 32'd1;
		mask = mask32[IDX_W-1:0];
		job.op = op_t'(item_s1.op);
		job.skey = keep_full_q ? item_s1.key : (item_s1.key & mask32);
		job.empty = keep_full_q ? empty_key_q : (empty_key_q & mask32);
		job.value = vprod_s1;
		job.hash = IDX_W'(hprod_s1 >> (6'd32 - {2'b00, bits}));
		job.mask = mask;
	end

endmodule

>>> sv/lphj_queue.sv
// Small FIFO of classified jobs between front and back.
module lphj_queue import lphj_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic wr_valid,
	output logic wr_ready,
	input job_t wr_job,
	output logic rd_valid,
	input logic rd_ready,
	output job_t rd_job
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	job_t slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [PTR_W:0] cnt_q;
	logic push, pop;

	assign wr_ready = cnt_q != (PTR_W+1)'(QUEUE_DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_job = slots_q[rptr_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop) rptr_q <= rptr_q + 1'b1;
			cnt_q <= cnt_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) slots_q[wptr_q] <= wr_job;
	end

endmodule

>>> sv/lphj_back.sv
// Back end: walks the bucket memory, updates accumulators and emits results.
module lphj_back import lphj_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	output logic job_ready,
	input job_t job,
	output logic out_valid,
	input logic out_ready,
	output out_item_t out_item
);

	back_state_t state_q, state_d;
	job_t job_q;
	logic [IDX_W-1:0] addr_q;
	logic [IDX_W:0] visits_q;
	logic [IDX_W-1:0] clr_q;
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_q;
	logic found_q, status_q;
	logic [31:0] mval_q;
	logic ready_q;

	logic ram_we;
	logic [IDX_W-1:0] ram_addr;
	logic [SLOT_W-1:0] ram_wdata, ram_rdata;
	logic [31:0] rkey, rval;
	logic is_empty, is_match, last_visit;

	lphj_ram #(.WIDTH(SLOT_W), .DEPTH(STORE_DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	// Store is not set at power-up; a sweep after reset sets every bit of it.
	assign rkey = ram_rdata[63:32];
	assign rval = ram_rdata[31:0];
	assign is_empty = rkey == job_q.empty;
	assign is_match = rkey == job_q.skey;
	assign last_visit = visits_q == ({1'b0, job_q.mask} + 1'b1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (job_valid) begin
				unique case (job.op)
					OP_CLEAR: state_d = ST_CLEAR;
					OP_INSERT, OP_PROBE: state_d = ST_READ;
					default: state_d = ST_DONE;
				endcase
			end
			ST_CLEAR: if (clr_q == IDX_W'(STORE_DEPTH - 1)) state_d = ready_q ? ST_DONE : ST_IDLE;
			ST_READ: state_d = ST_WAIT;
			ST_WAIT: state_d = ST_CHECK;
			ST_CHECK: begin
				if (is_empty || (job_q.op == OP_PROBE && is_match) || last_visit) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_DONE: if (out_ready || !out_valid) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		job_ready = state_q == ST_IDLE;
		ram_we = 1'b0;
		ram_addr = addr_q;
		ram_wdata = {job_q.skey, job_q.value};
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				ram_addr = clr_q;
				ram_wdata = ready_q ? {job_q.empty, job_q.empty} : {SLOT_W{1'b1}};
			end
			ST_CHECK: ram_we = job_q.op == OP_INSERT && is_empty;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ready_q <= 1'b0;
			clr_q <= '0;
			count_q <= '0;
			sum_q <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && (out_ready || !out_valid)) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == IDX_W'(STORE_DEPTH - 1)) ready_q <= 1'b1;
			end
			if (state_q == ST_IDLE && job_valid && job.op == OP_CLEAR) begin
				count_q <= '0;
				sum_q <= '0;
			end
			if (state_q == ST_CHECK && job_q.op == OP_PROBE && !is_empty && is_match) begin
				sum_q <= sum_q + SUM_W'(rval);
				if (count_q != COUNT_MAX) count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && job_valid) begin
			job_q <= job;
			addr_q <= job.hash;
			visits_q <= '0;
			found_q <= 1'b0;
			mval_q <= '0;
			status_q <= job.op == OP_INSERT;
		end
		if (state_q == ST_WAIT) visits_q <= visits_q + 1'b1;
		if (state_q == ST_CHECK) begin
			if (is_empty) begin
				if (job_q.op == OP_INSERT) status_q <= 1'b0;
			end else if (job_q.op == OP_PROBE && is_match) begin
				found_q <= 1'b1;
				mval_q <= rval;
			end
			addr_q <= (addr_q + 1'b1) & job_q.mask;
		end
		if (state_q == ST_DONE && (out_ready || !out_valid)) begin
			out_item.found <= found_q;
			out_item.match_value <= mval_q;
			out_item.status <= status_q;
			out_item.match_count <= count_q;
			out_item.value_sum <= sum_q;
		end
	end

	// visits_q counts buckets read; last_visit marks the final bucket of one pass.
	a_no_both: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_item.found && out_item.status)) else $error("found with full");
	a_mval_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_item.found) |-> out_item.match_value == '0)
		else $error("stray match value");
	a_clear_no_job: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !job_ready) else $error("job taken during clear");
	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_CLEAR || state_q == ST_CHECK)) else $error("stray write");

endmodule

>>> sv/linear_probe_hash_join_table.sv
// Top level of the linear probing hash join table.
//   channel  dir  handshake             payload
//   in       in   in_valid/in_ready     in_item_t (op, key)
//   out      out  out_valid/out_ready   out_item_t (found ... value_sum)
//   cfg      in   cfg_we                cfg_idx, cfg_data
// Each bucket visit passes three states of the single memory port: address,
// read latency, compare. The back takes a new job only once it is idle again,
// after the result of the last one has been handed to the output register.
// Clear sweeps all 1024 buckets, one per cycle; after reset a like sweep
// writing all ones runs once before the back takes its first job.
// The front hashes while the back probes; a two-entry queue separates them.
module linear_probe_hash_join_table import lphj_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_idx,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input in_item_t in_item,
	output logic out_valid,
	input logic out_ready,
	output out_item_t out_item
);

	logic f_valid, f_ready, b_valid, b_ready;
	job_t f_job, b_job;

	lphj_front u_front (
		.clk, .arst_n, .cfg_we, .cfg_idx, .cfg_data, .in_valid, .in_ready, .in_item,
		.job_valid(f_valid), .job_ready(f_ready), .job(f_job)
	);

	lphj_queue u_queue (
		.clk, .arst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_job(f_job),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_job(b_job)
	);

	lphj_back u_back (
		.clk, .arst_n, .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
		.out_valid, .out_ready, .out_item
	);

endmodule

>>> bench/linear_probe_hash_join_table_tb.sv
// Self-checking testbench for the linear probing hash join table.
module linear_probe_hash_join_table_tb;
	import lphj_pkg::*;

	class join_table_scoreboard;
		logic [31:0] keys [STORE_DEPTH];
		logic [31:0] vals [STORE_DEPTH];
		logic [CNT_W-1:0] joins;
		logic [SUM_W-1:0] sum;
		logic [3:0] bucket_bits;
		logic [31:0] empty_key, hash_mult, val_mult;
		logic keep_full;
		out_item_t awaited_q[$];
		int errors, checked, hits, fulls, clears;

		function new();
			foreach (keys[i]) begin
				keys[i] = '1;
				vals[i] = '1;
			end
			joins = '0;
			sum = '0;
			bucket_bits = BUCKET_BITS_RST;
			empty_key = EMPTY_KEY_RST;
			hash_mult = HASH_MULT_RST;
			val_mult = VAL_MULT_RST;
			keep_full = 1'b1;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [31:0] d);
			case (idx)
				CFG_BUCKET_BITS: bucket_bits = d[3:0];
				CFG_EMPTY_KEY: empty_key = d;
				CFG_HASH_MULT: hash_mult = d;
				CFG_VAL_MULT: val_mult = d;
				CFG_KEEP_FULL: keep_full = d[0];
				default: ;
			endcase
		endfunction

		function void note(in_item_t it);
			int b;
			logic [31:0] mask, empty, skey, prod, h;
			out_item_t r;
			b = int'(bucket_bits);
			if (b < 1) b = 1;
			if (b > LOG2_MAX_BUCKETS) b = LOG2_MAX_BUCKETS;
			mask = (32'd1 << b) - 32'd1;
			empty = keep_full ? empty_key : (empty_key & mask);
			skey = keep_full ? it.key : (it.key & mask);
			prod = it.key * hash_mult;
			h = prod >> (32 - b);
			r = '0;
			case (op_t'(it.op))
				OP_CLEAR: begin
					foreach (keys[i]) begin
						keys[i] = empty;
						vals[i] = empty;
					end
					joins = '0;
					sum = '0;
					clears++;
				end
				OP_INSERT: begin
					r.status = 1'b1;
					for (int n = 0; n <= int'(mask); n++) begin
						if (keys[h] == empty) begin
							keys[h] = skey;
							vals[h] = it.key * val_mult;
							r.status = 1'b0;
							break;
						end
						h = (h + 1) & mask;
					end
					if (r.status) fulls++;
				end
				OP_PROBE: begin
					for (int n = 0; n <= int'(mask); n++) begin
						if (keys[h] == empty) break;
						if (keys[h] == skey) begin
							r.found = 1'b1;
							r.match_value = vals[h];
							sum = sum + vals[h];
							if (joins != COUNT_MAX) joins = joins + 1;
							hits++;
							break;
						end
						h = (h + 1) & mask;
					end
				end
				default: ;
			endcase
			r.match_count = joins;
			r.value_sum = sum;
			awaited_q.push_back(r);
		endfunction

		function void check(out_item_t got);
			out_item_t e;
			checked++;
			if (awaited_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("result transfer with nothing expected: %h", got);
				return;
			end
			e = awaited_q.pop_front();
			if (got.found !== e.found || got.match_value !== e.match_value ||
					got.status !== e.status || got.match_count !== e.match_count ||
					got.value_sum !== e.value_sum) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch: found %b/%b value %h/%h status %b/%b",
						" count %h/%h sum %h/%h (exp/got)"},
						e.found, got.found, e.match_value, got.match_value, e.status, got.status,
						e.match_count, got.match_count, e.value_sum, got.value_sum);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_item;

	join_table_scoreboard sb = new();
	logic [31:0] key_pool[$];
	int stall_hold = 0;
	bit steady = 0;

	always #1 clk = ~clk;

	linear_probe_hash_join_table uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);

	always @(posedge clk) begin
		if (in_valid && in_ready) sb.note(in_item);
		if (out_valid && out_ready) sb.check(out_item);
	end

	always @(posedge clk) begin
		if (stall_hold > 0) begin
			stall_hold <= stall_hold - 1;
		end else if (steady) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(0, 2) != 0);
			stall_hold <= ($urandom_range(0, 19) == 0) ? $urandom_range(15, 60) : $urandom_range(0, 3);
		end
	end

	task automatic send(op_t op, logic [31:0] k);
		int r, gap;
		r = $urandom_range(0, 99);
		gap = steady ? 0 : (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= '{op: op, key: k};
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain(int settle);
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.awaited_q.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic cfg_write(cfg_idx_t idx, logic [31:0] d);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= d;
		@(posedge clk);
		sb.set_reg(idx, d);
	endtask

	task automatic setup_phase(int p);
		logic [3:0] bb;
		logic [31:0] ek, hm, vf;
		logic kf;
		case (p)
			1: begin bb = 4'd1; ek = 0; hm = $urandom; vf = '1; kf = 1'b1; end
			2: begin bb = 4'd0; ek = 5; hm = 32'h9E37_79B9; vf = 7; kf = 1'b0; end
			3: begin bb = 4'd15; ek = '1; hm = 0; vf = 0; kf = 1'b1; end
			4: begin bb = 4'd3; ek = 0; hm = $urandom; vf = $urandom; kf = 1'b0; end
			5: begin bb = 4'd10; ek = $urandom; hm = $urandom; vf = $urandom; kf = 1'b1; end
			6: begin bb = 4'd4; ek = '1; hm = 1; vf = $urandom; kf = 1'b1; end
			7: begin bb = 4'd2; ek = 32'hAAAA_AAAA; hm = $urandom; vf = 1; kf = 1'b0; end
			8: begin bb = 4'd6; ek = 0; hm = '1; vf = $urandom; kf = 1'b1; end
			9: begin bb = 4'd5; ek = 1; hm = $urandom; vf = $urandom; kf = 1'b0; end
			default: begin
				bb = 4'd10; ek = '1; hm = HASH_MULT_RST; vf = VAL_MULT_RST; kf = 1'b1;
			end
		endcase
		cfg_write(CFG_BUCKET_BITS, {28'd0, bb});
		cfg_write(CFG_EMPTY_KEY, ek);
		cfg_write(CFG_HASH_MULT, hm);
		cfg_write(CFG_VAL_MULT, vf);
		cfg_write(CFG_KEEP_FULL, {31'd0, kf});
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] fresh_key();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 63);
			1: return sb.empty_key;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_phase(int items);
		int r;
		logic [31:0] k;
		key_pool.delete();
		if ($urandom_range(0, 3) != 0) send(OP_CLEAR, $urandom);
		for (int i = 0; i < items; i++) begin
			r = $urandom_range(0, 99);
			if (i == items / 2 && $urandom_range(0, 1)) drain(0);
			if (r < 3) begin
				send(OP_CLEAR, $urandom);
				key_pool.delete();
			end else if (r < 6) begin
				send(OP_NONE, $urandom);
			end else if (r < 50) begin
				k = (key_pool.size() > 0 && r < 12) ?
					key_pool[$urandom_range(0, key_pool.size() - 1)] : fresh_key();
				key_pool.push_back(k);
				send(OP_INSERT, k);
			end else begin
				k = (key_pool.size() > 0 && r < 85) ?
					key_pool[$urandom_range(0, key_pool.size() - 1)] : fresh_key();
				send(OP_PROBE, k);
			end
		end
		drain(20);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send(OP_INSERT, 32'h0000_0000);
		send(OP_INSERT, 32'hFFFF_FFFF);
		send(OP_INSERT, 32'h0000_0000);
		send(OP_INSERT, 32'h0000_0001);
		send(OP_INSERT, 32'h8000_0000);
		send(OP_PROBE, 32'h0000_0000);
		send(OP_PROBE, 32'hFFFF_FFFF);
		send(OP_PROBE, 32'h0000_0001);
		send(OP_PROBE, 32'h8000_0000);
		send(OP_PROBE, 32'h7FFF_FFFF);
		send(OP_NONE, 32'hFFFF_FFFF);
		send(OP_CLEAR, 32'h1234_5678);
		send(OP_PROBE, 32'h0000_0000);
		drain(20);
		setup_phase(1);
		send(OP_INSERT, 32'h0000_0003);
		send(OP_INSERT, 32'hFFFF_FFFE);
		send(OP_INSERT, 32'h5555_5555);
		send(OP_PROBE, 32'h5555_5555);
		send(OP_PROBE, 32'hFFFF_FFFE);
		send(OP_PROBE, 32'h0000_0003);
		send(OP_INSERT, 32'h0000_0000);
		drain(20);
		for (int p = 1; p <= 10; p++) begin
			steady = (p == 6);
			setup_phase(p);
			random_phase(62);
		end
		$display("ran %0d results over 11 register settings: %0d clears, %0d matches, %0d full inserts",
			sb.checked, sb.clears, sb.hits, sb.fulls);
		$display("bucket counts 2 to 1024, masked and full keys, empty-key and idle-op cases included");
		if (sb.errors == 0 && sb.awaited_q.size() == 0) begin
			$display("linear_probe_hash_join_table_tb: clean");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.errors, sb.awaited_q.size());
			$display("linear_probe_hash_join_table_tb: errors");
		end
		$finish;
	end

	initial begin
		#40000000;
		$display("timeout with %0d results outstanding", sb.awaited_q.size());
		$display("linear_probe_hash_join_table_tb: errors");
		$finish;
	end

endmodule
